>>> rtl/oalt_pkg.sv
package oalt_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_LOCATE = 2'd3
  } cmd_t;

  // Broadcast from the control logic to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos0;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> rtl/oalt_if.sv
interface oalt_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        cmd;
  logic [oalt_pkg::POS_W-1:0]        position;
  logic signed [oalt_pkg::DATA_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface oalt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [oalt_pkg::DATA_W-1:0] element;
  logic [oalt_pkg::POS_W-1:0]        found_position;
  logic [oalt_pkg::POS_W-1:0]        count;

  modport source (output valid, output ok, output element, output found_position,
                  output count, input ready);
  modport sink   (input valid, input ok, input element, input found_position,
                  input count, output ready);
endinterface

>>> rtl/ordered_array_list_table_top.sv
// Ordered list of CAPACITY signed 32-bit words held in a chain of cells, one word per
// cell, addressed by 1-based position. Every cell shifts or compares in the same clock,
// so each command (insert, delete, get, locate) acts on all cells at once and the result
// appears in the output register on the following cycle; a new command is taken every
// cycle as long as the result side keeps up. Entries hold no reset value and need no
// clearing pass; only the fill count and output valid are cleared by reset. Positions
// above 31 cannot be addressed, and count and found_position carry the low five bits.
module ordered_array_list_table_top #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  oalt_in_if.sink     in_ch,
  oalt_out_if.source  out_ch
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int EW   = ((CW > oalt_pkg::POS_W) ? CW : oalt_pkg::POS_W) + 1;
  localparam int NSEL = (CAPACITY < 31) ? CAPACITY : 31;

  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;

  logic                        out_valid_r;
  logic                        ok_r;
  logic [oalt_pkg::DATA_W-1:0] element_r;
  logic [oalt_pkg::POS_W-1:0]  found_r;
  logic [oalt_pkg::POS_W-1:0]  count_r;

  logic                        accept;
  oalt_pkg::cmd_t              cmd;
  logic [EW-1:0]               pos_e;
  logic [EW-1:0]               fill_e;
  logic [EW-1:0]               fill_nxt_e;
  logic                        ins_ok;
  logic                        rd_ok;
  logic                        ok_nxt;
  logic [oalt_pkg::DATA_W-1:0] element_nxt;
  logic [oalt_pkg::POS_W-1:0]  found_nxt;
  logic [oalt_pkg::DATA_W-1:0] rd_data;

  oalt_pkg::cell_ctrl_t        ctrl;
  logic [oalt_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [oalt_pkg::DATA_W-1:0] from_left [CAPACITY];
  logic [oalt_pkg::DATA_W-1:0] from_right [CAPACITY];
  logic [CAPACITY-1:0]         cell_match;
  logic [CAPACITY-1:0]         cell_sel;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = oalt_pkg::cmd_t'(in_ch.cmd);

  assign pos_e  = EW'(in_ch.position);
  assign fill_e = EW'(fill_r);

  assign ins_ok = (in_ch.position != '0) && (pos_e <= fill_e + EW'(1))
                  && (fill_r != CW'(CAPACITY));
  assign rd_ok  = (in_ch.position != '0) && (pos_e <= fill_e);

  assign ctrl.ins   = accept && (cmd == oalt_pkg::CMD_INSERT) && ins_ok;
  assign ctrl.del   = accept && (cmd == oalt_pkg::CMD_DELETE) && rd_ok;
  assign ctrl.pos0  = in_ch.position - oalt_pkg::POS_W'(1);
  assign ctrl.value = in_ch.value;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign from_left[g] = '0;
    end else begin : g_mid_l
      assign from_left[g] = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign from_right[g] = '0;
    end else begin : g_mid_r
      assign from_right[g] = cell_data[g+1];
    end

    oalt_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  (from_left[g]),
      .right_data (from_right[g]),
      .data       (cell_data[g]),
      .match      (cell_match[g]),
      .sel        (cell_sel[g])
    );
  end

  // Only the first 31 cells can be addressed by a 5-bit position.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < NSEL; i++) begin
      if (cell_sel[i]) begin
        rd_data = rd_data | cell_data[i];
      end
    end
  end

  // The lowest live cell that matches wins.
  always_comb begin
    found_nxt = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i] && (i < int'(fill_r))) begin
        found_nxt = oalt_pkg::POS_W'(i + 1);
      end
    end
  end

  always_comb begin
    fill_nxt    = fill_r;
    ok_nxt      = 1'b0;
    element_nxt = '0;
    unique case (cmd)
      oalt_pkg::CMD_INSERT: begin
        ok_nxt = ins_ok;
        if (ins_ok) begin
          fill_nxt = fill_r + CW'(1);
        end
      end
      oalt_pkg::CMD_DELETE: begin
        ok_nxt = rd_ok;
        if (rd_ok) begin
          fill_nxt    = fill_r - CW'(1);
          element_nxt = rd_data;
        end
      end
      oalt_pkg::CMD_GET: begin
        ok_nxt = rd_ok;
        if (rd_ok) begin
          element_nxt = rd_data;
        end
      end
      oalt_pkg::CMD_LOCATE: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  assign fill_nxt_e = EW'(fill_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r      <= ok_nxt;
      element_r <= element_nxt;
      found_r   <= (cmd == oalt_pkg::CMD_LOCATE) ? found_nxt : '0;
      count_r   <= fill_nxt_e[oalt_pkg::POS_W-1:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ok             = ok_r;
  assign out_ch.element        = element_r;
  assign out_ch.found_position = found_r;
  assign out_ch.count          = count_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> fill_r == $past(fill_r) + CW'(1))
    else $error("successful insert did not grow the list");

  a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.del |=> fill_r == $past(fill_r) - CW'(1))
    else $error("successful delete did not shrink the list");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ok_r) |-> (element_r == '0 && found_r == '0))
    else $error("failed command carries data");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty output register");

endmodule

>>> rtl/oalt_cell.sv
module oalt_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  oalt_pkg::cell_ctrl_t          ctrl,
  input  logic [oalt_pkg::DATA_W-1:0]   left_data,
  input  logic [oalt_pkg::DATA_W-1:0]   right_data,
  output logic [oalt_pkg::DATA_W-1:0]   data,
  output logic                          match,
  output logic                          sel
);

  logic [oalt_pkg::DATA_W-1:0] data_r;
  logic [oalt_pkg::DATA_W-1:0] data_nxt;
  logic                        above;

  assign sel   = (32'(ctrl.pos0) == IDX);
  assign above = (32'(ctrl.pos0) < IDX);
  assign match = (data_r == ctrl.value);
  assign data  = data_r;

  // Insert opens a slot at the target by moving everything above it up one cell;
  // delete closes the slot by pulling the upper part down one cell.
  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (sel) begin
        data_nxt = ctrl.value;
      end else if (above) begin
        data_nxt = left_data;
      end
    end else if (ctrl.del) begin
      if (sel || above) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> sim/tb_ordered_array_list_table_top.sv
module tb_ordered_array_list_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = oalt_pkg::DATA_W;
  localparam int POS_W  = oalt_pkg::POS_W;

  localparam int LIST_CAP     = 16;
  localparam int RAND_ITEMS   = 1000;
  localparam int RUN_LIMIT_NS = 2_000_000;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] element;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  count;
  } list_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  oalt_in_if  in_ch();
  oalt_out_if out_ch();

  ordered_array_list_table_top #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the list contents, updated at each accepted transaction.
  logic signed [DATA_W-1:0] list_mem [LIST_CAP];
  int                       list_len;
  list_result_t             pending_results [$];

  int error_count;
  int checked_count;
  int rejected_count;
  int cmd_seen [4];

  int send_idle_pct = 30;
  int recv_idle_pct = 30;
  int hold_request;
  int stall_left;

  function automatic list_result_t apply_command(oalt_pkg::cmd_t c, logic [POS_W-1:0] p,
                                                 logic signed [DATA_W-1:0] v);
    list_result_t r;
    int pos;
    r   = '0;
    pos = p;
    case (c)
      oalt_pkg::CMD_INSERT: begin
        if (pos >= 1 && pos <= list_len + 1 && list_len < LIST_CAP) begin
          for (int k = list_len; k >= pos; k--) list_mem[k] = list_mem[k-1];
          list_mem[pos-1] = v;
          list_len++;
          r.ok = 1'b1;
        end
      end
      oalt_pkg::CMD_DELETE: begin
        if (pos >= 1 && pos <= list_len) begin
          r.element = list_mem[pos-1];
          for (int k = pos; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
          r.ok = 1'b1;
        end
      end
      oalt_pkg::CMD_GET: begin
        if (pos >= 1 && pos <= list_len) begin
          r.element = list_mem[pos-1];
          r.ok      = 1'b1;
        end
      end
      default: begin
        r.ok = 1'b1;
        for (int k = 0; k < list_len; k++) begin
          if (list_mem[k] == v) begin
            r.found_position = POS_W'(k + 1);
            break;
          end
        end
      end
    endcase
    r.count = POS_W'(list_len);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -1;
      4, 5:    return DATA_W'($urandom_range(7));  // small values make duplicates likely
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions inside the legal range, with some noise across the whole field.
  function automatic logic [POS_W-1:0] pick_position(oalt_pkg::cmd_t c);
    if ($urandom_range(99) < 15 || c == oalt_pkg::CMD_LOCATE) return POS_W'($urandom_range(31));
    if (c == oalt_pkg::CMD_INSERT) return POS_W'($urandom_range(list_len + 1, 1));
    return (list_len > 0) ? POS_W'($urandom_range(list_len, 1)) : POS_W'(1);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_search_value();
    if (list_len > 0 && $urandom_range(99) < 60) return list_mem[$urandom_range(list_len - 1)];
    return pick_value();
  endfunction

  task automatic send_command(oalt_pkg::cmd_t c, logic [POS_W-1:0] p,
                              logic signed [DATA_W-1:0] v);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct)
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.position <= p;
    in_ch.value    <= v;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_command(c, p, v));
    cmd_seen[c]++;
    if (!pending_results[$].ok) rejected_count++;
  endtask

  task automatic send_random_command(int trend);
    int             w;
    oalt_pkg::cmd_t c;
    int             ins_lim;
    int             del_lim;
    int             get_lim;
    w = $urandom_range(99);
    case (trend)
      0:       begin ins_lim = 55; del_lim = 70; get_lim = 85; end
      1:       begin ins_lim = 15; del_lim = 70; get_lim = 85; end
      default: begin ins_lim = 30; del_lim = 60; get_lim = 80; end
    endcase
    if (w < ins_lim)      c = oalt_pkg::CMD_INSERT;
    else if (w < del_lim) c = oalt_pkg::CMD_DELETE;
    else if (w < get_lim) c = oalt_pkg::CMD_GET;
    else                  c = oalt_pkg::CMD_LOCATE;
    send_command(c, pick_position(c),
                 (c == oalt_pkg::CMD_LOCATE) ? pick_search_value() : pick_value());
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result side: random stalls, plus a long hold when a test asks for one.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < recv_idle_pct) begin
      out_ch.ready <= 1'b0;
      stall_left = (($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1)) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with none expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_ch.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ch.ok);
          error_count++;
        end
        if (out_ch.element !== want.element) begin
          $error("element: expected %0d, got %0d", $signed(want.element), out_ch.element);
          error_count++;
        end
        if (out_ch.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d", want.found_position,
                 out_ch.found_position);
          error_count++;
        end
        if (out_ch.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_ch.count);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_command(oalt_pkg::CMD_GET, 1, 0);
    send_command(oalt_pkg::CMD_DELETE, 1, 0);
    send_command(oalt_pkg::CMD_DELETE, 0, 0);
    send_command(oalt_pkg::CMD_LOCATE, 0, 0);
    send_command(oalt_pkg::CMD_INSERT, 0, 5);
    send_command(oalt_pkg::CMD_INSERT, 2, 5);
    send_command(oalt_pkg::CMD_INSERT, 31, -1);
  endtask

  task automatic test_edge_values();
    send_command(oalt_pkg::CMD_INSERT, 1, WORD_MIN);
    send_command(oalt_pkg::CMD_INSERT, 2, WORD_MAX);
    send_command(oalt_pkg::CMD_INSERT, 1, 0);
    send_command(oalt_pkg::CMD_INSERT, 2, -1);
    send_command(oalt_pkg::CMD_INSERT, 5, -1);
    send_command(oalt_pkg::CMD_INSERT, 7, 9);
    send_command(oalt_pkg::CMD_LOCATE, 0, -1);
    send_command(oalt_pkg::CMD_LOCATE, 17, WORD_MAX);
    send_command(oalt_pkg::CMD_LOCATE, 31, 12345);
    send_command(oalt_pkg::CMD_GET, 0, 0);
    send_command(oalt_pkg::CMD_GET, 5, 0);
    send_command(oalt_pkg::CMD_GET, 6, 0);
    send_command(oalt_pkg::CMD_GET, 31, 0);
    send_command(oalt_pkg::CMD_DELETE, 3, 0);
    send_command(oalt_pkg::CMD_DELETE, 31, 0);
    send_command(oalt_pkg::CMD_DELETE, 4, 0);
    send_command(oalt_pkg::CMD_GET, 1, WORD_MAX);
  endtask

  // Empty the list, fill to capacity with distinct values, hit the full cases, then drain to empty.
  task automatic test_full_list();
    int unsigned base;
    int          k;
    base = $urandom;
    k    = 0;
    while (list_len > 0)
      send_command(oalt_pkg::CMD_DELETE, POS_W'($urandom_range(list_len, 1)), pick_value());
    while (list_len < LIST_CAP) begin
      k++;
      send_command(oalt_pkg::CMD_INSERT,
                   ($urandom_range(3) == 0) ? POS_W'($urandom_range(list_len + 1, 1))
                                            : POS_W'(list_len + 1),
                   DATA_W'((base + k) * 32'h9E37_79B1));
    end
    send_command(oalt_pkg::CMD_LOCATE, 0, list_mem[LIST_CAP-1]);
    send_command(oalt_pkg::CMD_INSERT, 1, WORD_MAX);
    send_command(oalt_pkg::CMD_INSERT, 17, WORD_MIN);
    send_command(oalt_pkg::CMD_GET, 16, 0);
    send_command(oalt_pkg::CMD_GET, 17, 0);
    send_command(oalt_pkg::CMD_DELETE, 16, 0);
    send_command(oalt_pkg::CMD_INSERT, 16, WORD_MIN);
    while (list_len > 0) send_command(oalt_pkg::CMD_DELETE, 1, pick_value());
    send_command(oalt_pkg::CMD_DELETE, 1, 0);
    wait_for_results();
  endtask

  // The result side holds off while commands keep coming, so the block must stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_request  = 150;
    repeat (40) send_random_command(0);
    wait_for_results();
    send_idle_pct = 30;
  endtask

  task automatic test_back_to_back();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 120; n++) send_random_command((n / 40) % 3);
    wait_for_results();
    send_idle_pct = 30;
    recv_idle_pct = 30;
  endtask

  task automatic test_random_mix();
    int idle_levels [3] = '{0, 20, 50};
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 200 == 0) begin
        send_idle_pct = idle_levels[$urandom_range(2)];
        recv_idle_pct = idle_levels[$urandom_range(2)];
      end
      send_random_command((n / 50) % 3);
      if (n % 300 == 299) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.cmd      = oalt_pkg::CMD_INSERT;
    in_ch.position = '0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    list_len       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edge_values();
    wait_for_results();
    test_full_list();
    test_backpressure();
    test_back_to_back();
    test_random_mix();

    wait_for_results();
    repeat (5) @(posedge clk);
    $display("Covered %0d transactions: %0d insert, %0d delete, %0d get, %0d locate, %0d rejected.",
             cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
             cmd_seen[oalt_pkg::CMD_INSERT], cmd_seen[oalt_pkg::CMD_DELETE],
             cmd_seen[oalt_pkg::CMD_GET], cmd_seen[oalt_pkg::CMD_LOCATE], rejected_count);
    $display("Checked %0d results against the shadow list, %0d mismatches.",
             checked_count, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS * 1ns);
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/oalt_pkg.sv
rtl/oalt_if.sv
rtl/oalt_cell.sv
rtl/ordered_array_list_table_top.sv
sim/tb_ordered_array_list_table_top.sv
